FILE: sv/sbb_pkg.sv
// shared types, codes and defaults for the spi slave byte buffer
`default_nettype none
package sbb_pkg;

  localparam int RX_DEPTH_DEF = 256;
  localparam int TX_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    CMD_RX       = 2'd0,
    CMD_TX_READY = 2'd1,
    CMD_POP      = 2'd2,
    CMD_LOAD     = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BUSY     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  // result fields known at request time; the stored bytes come from the rams
  typedef struct packed {
    logic       tx_valid;
    logic       tx_bypass;
    logic [7:0] tx_bypass_byte;
    logic       pop_valid;
    logic       bytes_ready;
    logic       ready_pin;
    status_t    status;
  } sbb_meta_t;

  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage
`default_nettype wire

FILE: sv/sbb_req_if.sv
// request channel: command and byte fields
`default_nettype none
interface sbb_req_if import sbb_pkg::*; ();
  logic       valid;
  logic       ready;
  cmd_t       cmd;
  logic [7:0] rx_data;
  logic [7:0] tx_data;
  logic       tx_last;

  modport source (output valid, cmd, rx_data, tx_data, tx_last, input ready);
  modport sink (input valid, cmd, rx_data, tx_data, tx_last, output ready);
endinterface
`default_nettype wire

FILE: sv/sbb_res_if.sv
// result channel: transmit byte, popped byte and status
`default_nettype none
interface sbb_res_if import sbb_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       pop_valid;
  logic [7:0] pop_data;
  logic       bytes_ready;
  logic       ready_pin;
  status_t    status;

  modport source (output valid, tx_valid, tx_byte, pop_valid, pop_data, bytes_ready,
                  ready_pin, status, input ready);
  modport sink (input valid, tx_valid, tx_byte, pop_valid, pop_data, bytes_ready,
                ready_pin, status, output ready);
endinterface
`default_nettype wire

FILE: sv/sbb_ram.sv
// generic single write port ram with registered read
`default_nettype none
module sbb_ram import sbb_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = addr_w(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/sbb_ctrl.sv
// pointer and transmit state control, ram addressing and result staging
`default_nettype none
module sbb_ctrl import sbb_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF,
  localparam int RAW = addr_w(RX_DEPTH),
  localparam int TAW = addr_w(TX_DEPTH),
  localparam int LW = $clog2(TX_DEPTH + 1)
) (
  input  logic           clk,
  input  logic           rst,
  sbb_req_if.sink        req,
  input  logic           res_ready,
  output logic           res_valid,
  output sbb_meta_t      meta,
  output logic           rx_we,
  output logic [RAW-1:0] rx_waddr,
  output logic [7:0]     rx_wdata,
  output logic           rx_re,
  output logic [RAW-1:0] rx_raddr,
  output logic           tx_we,
  output logic [TAW-1:0] tx_waddr,
  output logic [7:0]     tx_wdata,
  output logic           tx_re,
  output logic [TAW-1:0] tx_raddr
);

  logic           accept;
  logic [RAW-1:0] rx_write_pos, rx_write_pos_next;
  logic [RAW-1:0] rx_read_pos, rx_read_pos_next;
  logic [LW-1:0]  tx_length, tx_length_next;
  logic [LW-1:0]  tx_next_pos, tx_next_pos_next;
  logic [LW-1:0]  load_count, load_count_next;
  logic           tx_active, tx_active_next;
  logic           ready_level, ready_level_next;
  sbb_meta_t      meta_next;

  function automatic logic [RAW-1:0] rx_advance(input logic [RAW-1:0] pos);
    return (pos == RAW'(RX_DEPTH - 1)) ? '0 : RAW'(pos + 1'b1);
  endfunction

  assign req.ready = !res_valid || res_ready;
  assign accept    = req.valid && req.ready;
  assign rx_re     = accept;
  assign tx_re     = accept;
  assign rx_wdata  = req.rx_data;
  assign tx_wdata  = req.tx_data;

  always_comb begin
    rx_write_pos_next = rx_write_pos;
    rx_read_pos_next  = rx_read_pos;
    tx_length_next    = tx_length;
    tx_next_pos_next  = tx_next_pos;
    load_count_next   = load_count;
    tx_active_next    = tx_active;
    ready_level_next  = ready_level;
    rx_we             = 1'b0;
    rx_waddr          = rx_write_pos;
    rx_raddr          = rx_read_pos;
    tx_we             = 1'b0;
    tx_waddr          = load_count[TAW-1:0];
    tx_raddr          = tx_next_pos[TAW-1:0];
    meta_next         = '0;
    meta_next.status  = STATUS_OK;
    meta_next.tx_bypass_byte = req.tx_data;

    unique case (req.cmd)
      CMD_RX: begin
        if (!tx_active) begin
          rx_we             = accept;
          rx_write_pos_next = rx_advance(rx_write_pos);
        end
      end
      CMD_TX_READY: begin
        if (tx_active && tx_next_pos < tx_length) begin
          meta_next.tx_valid = 1'b1;
          tx_next_pos_next   = LW'(tx_next_pos + 1'b1);
        end else begin
          tx_active_next   = 1'b0;
          ready_level_next = 1'b1;
        end
      end
      CMD_POP: begin
        if (rx_write_pos != rx_read_pos) begin
          meta_next.pop_valid = 1'b1;
          rx_read_pos_next    = rx_advance(rx_read_pos);
        end
      end
      CMD_LOAD: begin
        tx_raddr = '0;
        if (tx_active) begin
          meta_next.status = STATUS_BUSY;
        end else if (load_count == LW'(TX_DEPTH)) begin
          meta_next.status = STATUS_OVERFLOW;
          load_count_next  = '0;
        end else begin
          tx_we           = accept;
          load_count_next = LW'(load_count + 1'b1);
          if (req.tx_last) begin
            tx_length_next      = LW'(load_count + 1'b1);
            load_count_next     = '0;
            tx_active_next      = 1'b1;
            ready_level_next    = 1'b0;
            tx_next_pos_next    = LW'(1);
            meta_next.tx_valid  = 1'b1;
            // first byte is the one being written now
            meta_next.tx_bypass = (load_count == '0);
          end
        end
      end
    endcase

    meta_next.bytes_ready = (rx_write_pos_next != rx_read_pos_next);
    meta_next.ready_pin   = ready_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_write_pos <= '0;
      rx_read_pos  <= '0;
      tx_length    <= '0;
      tx_next_pos  <= '0;
      load_count   <= '0;
      tx_active    <= 1'b0;
      ready_level  <= 1'b1;
      res_valid    <= 1'b0;
    end else begin
      if (accept) begin
        rx_write_pos <= rx_write_pos_next;
        rx_read_pos  <= rx_read_pos_next;
        tx_length    <= tx_length_next;
        tx_next_pos  <= tx_next_pos_next;
        load_count   <= load_count_next;
        tx_active    <= tx_active_next;
        ready_level  <= ready_level_next;
        res_valid    <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      meta <= meta_next;
    end
  end

endmodule
`default_nettype wire

FILE: sv/spi_slave_byte_buffer.sv
// an accepted request's result is registered and shown on the result channel in the next cycle
// throughput: one request per cycle; the result is held in the staging register
// and the ram read registers until taken, and a new request enters as it leaves
// reset: synchronous; positions, counts and transmit mode clear, ready line goes high,
// result channel empties; ram contents are not cleared
`default_nettype none
module spi_slave_byte_buffer import sbb_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sbb_req_if.sink   req,
  sbb_res_if.source res
);

  localparam int RAW = addr_w(RX_DEPTH);
  localparam int TAW = addr_w(TX_DEPTH);

  sbb_meta_t      meta;
  logic           rx_we, rx_re, tx_we, tx_re;
  logic [RAW-1:0] rx_waddr, rx_raddr;
  logic [TAW-1:0] tx_waddr, tx_raddr;
  logic [7:0]     rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  sbb_ctrl #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .res_ready(res.ready),
    .res_valid(res.valid),
    .meta     (meta),
    .rx_we    (rx_we),
    .rx_waddr (rx_waddr),
    .rx_wdata (rx_wdata),
    .rx_re    (rx_re),
    .rx_raddr (rx_raddr),
    .tx_we    (tx_we),
    .tx_waddr (tx_waddr),
    .tx_wdata (tx_wdata),
    .tx_re    (tx_re),
    .tx_raddr (tx_raddr)
  );

  sbb_ram #(
    .WIDTH(8),
    .DEPTH(RX_DEPTH)
  ) u_rx_ram (
    .clk  (clk),
    .we   (rx_we),
    .waddr(rx_waddr),
    .wdata(rx_wdata),
    .re   (rx_re),
    .raddr(rx_raddr),
    .rdata(rx_rdata)
  );

  sbb_ram #(
    .WIDTH(8),
    .DEPTH(TX_DEPTH)
  ) u_tx_ram (
    .clk  (clk),
    .we   (tx_we),
    .waddr(tx_waddr),
    .wdata(tx_wdata),
    .re   (tx_re),
    .raddr(tx_raddr),
    .rdata(tx_rdata)
  );

  assign res.tx_valid    = meta.tx_valid;
  assign res.tx_byte     = !meta.tx_valid ? 8'd0 :
                           (meta.tx_bypass ? meta.tx_bypass_byte : tx_rdata);
  assign res.pop_valid   = meta.pop_valid;
  assign res.pop_data    = meta.pop_valid ? rx_rdata : 8'd0;
  assign res.bytes_ready = meta.bytes_ready;
  assign res.ready_pin   = meta.ready_pin;
  assign res.status      = meta.status;

`ifndef SYNTH
  a_one_byte_kind: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !(res.tx_valid && res.pop_valid))
    else $error("transmit and pop in one result");

  a_tx_pin_low: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.tx_valid) |-> !res.ready_pin)
    else $error("byte sent while ready line high");

  a_reject_quiet: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status != STATUS_OK) |-> (!res.tx_valid && !res.pop_valid))
    else $error("rejected load produced data");

  a_status_only_load: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd != CMD_LOAD) |=> (res.status == STATUS_OK))
    else $error("status set for a non-load request");
`endif

endmodule
`default_nettype wire

FILE: tb/sbb_buffer_checker.sv
// checker for the spi slave byte buffer: predicts every result and compares it field by field
`default_nettype none
module sbb_buffer_checker import sbb_pkg::*; #(
  parameter int RX_DEPTH = RX_DEPTH_DEF,
  parameter int TX_DEPTH = TX_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  sbb_req_if   req,
  sbb_res_if   res,
  output int   errors,
  output int   outstanding
);

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       pop_valid;
    logic [7:0] pop_data;
    logic       bytes_ready;
    logic       ready_pin;
    status_t    status;
  } buf_result_t;

  logic [7:0]  rx_mem [RX_DEPTH];
  logic [7:0]  tx_mem [TX_DEPTH];
  int          rx_wr;
  int          rx_rd;
  int          msg_len;
  int          send_pos;
  int          load_cnt;
  logic        sending;
  logic        ready_lvl;
  buf_result_t buffer_results_q[$];
  buf_result_t want;

  function automatic buf_result_t step_buffer(cmd_t cmd, logic [7:0] rx_data,
                                              logic [7:0] tx_data, logic tx_last);
    buf_result_t r;
    r = '0;
    case (cmd)
      CMD_RX: begin
        if (!sending) begin
          rx_mem[rx_wr] = rx_data;
          rx_wr = (rx_wr + 1) % RX_DEPTH;
        end
      end
      CMD_TX_READY: begin
        if (sending && send_pos < msg_len) begin
          r.tx_valid = 1'b1;
          r.tx_byte = tx_mem[send_pos];
          send_pos++;
        end else begin
          sending = 1'b0;
          ready_lvl = 1'b1;
        end
      end
      CMD_POP: begin
        if (rx_wr != rx_rd) begin
          r.pop_valid = 1'b1;
          r.pop_data = rx_mem[rx_rd];
          rx_rd = (rx_rd + 1) % RX_DEPTH;
        end
      end
      CMD_LOAD: begin
        if (sending) begin
          r.status = STATUS_BUSY;
        end else if (load_cnt >= TX_DEPTH) begin
          r.status = STATUS_OVERFLOW;
          load_cnt = 0;
        end else begin
          tx_mem[load_cnt] = tx_data;
          load_cnt++;
          if (tx_last) begin
            msg_len = load_cnt;
            load_cnt = 0;
            sending = 1'b1;
            ready_lvl = 1'b0;
            r.tx_valid = 1'b1;
            r.tx_byte = tx_mem[0];
            send_pos = 1;
          end
        end
      end
    endcase
    r.bytes_ready = (rx_wr != rx_rd);
    r.ready_pin = ready_lvl;
    return r;
  endfunction

  task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (got_val !== exp_val) begin
      $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_wr = 0;
      rx_rd = 0;
      msg_len = 0;
      send_pos = 0;
      load_cnt = 0;
      sending = 1'b0;
      ready_lvl = 1'b1;
      buffer_results_q.delete();
      errors = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (buffer_results_q.size() == 0) begin
          $display("%0t: result with nothing expected, tx %0h pop %0h", $time, res.tx_byte,
                   res.pop_data);
          errors++;
        end else begin
          want = buffer_results_q.pop_front();
          check_field("tx_valid", want.tx_valid, res.tx_valid);
          check_field("tx_byte", want.tx_byte, res.tx_byte);
          check_field("pop_valid", want.pop_valid, res.pop_valid);
          check_field("pop_data", want.pop_data, res.pop_data);
          check_field("bytes_ready", want.bytes_ready, res.bytes_ready);
          check_field("ready_pin", want.ready_pin, res.ready_pin);
          check_field("status", want.status, res.status);
        end
      end
      if (req.valid && req.ready) begin
        buffer_results_q.push_back(step_buffer(req.cmd, req.rx_data, req.tx_data,
                                               req.tx_last));
      end
    end
    outstanding = buffer_results_q.size();
  end

endmodule
`default_nettype wire

FILE: tb/tb_spi_slave_byte_buffer.sv
// top of the spi slave byte buffer testbench: clock, reset, requests, result stalls, verdict
`default_nettype none
module tb_spi_slave_byte_buffer import sbb_pkg::*;;

  localparam int RX_DEPTH = RX_DEPTH_DEF;
  localparam int TX_DEPTH = TX_DEPTH_DEF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors;
  int   outstanding;
  int   sent;
  int   req_max_gap;
  int   res_max_stall;
  int   res_stall;
  int   draw;
  logic res_taken = 1'b0;
  logic seen_ready_pin;
  logic seen_bytes_ready;

  sbb_req_if req ();
  sbb_res_if res ();

  spi_slave_byte_buffer #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res)
  );

  sbb_buffer_checker #(
    .RX_DEPTH(RX_DEPTH),
    .TX_DEPTH(TX_DEPTH)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .errors(errors),
    .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #1000000;
    $display("tb_spi_slave_byte_buffer: errors");
    $finish;
  end

  always @(posedge clk) begin
    res_taken <= res.valid && res.ready;
    if (res.valid && res.ready) begin
      seen_ready_pin <= res.ready_pin;
      seen_bytes_ready <= res.bytes_ready;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      res_stall <= 0;
    end else if (res_taken) begin
      draw = $urandom_range(0, res_max_stall);
      res.ready <= (draw == 0);
      res_stall <= (draw == 0) ? 0 : draw - 1;
    end else if (res_stall != 0) begin
      res.ready <= 1'b0;
      res_stall <= res_stall - 1;
    end else begin
      res.ready <= 1'b1;
    end
  end

  function automatic int pick_limit();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 2;
      default: return 13;
    endcase
  endfunction

  task automatic issue(cmd_t cmd, logic [7:0] rx_data, logic [7:0] tx_data, logic tx_last);
    int gap;
    gap = $urandom_range(0, req_max_gap);
    @(negedge clk);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.cmd <= cmd;
    req.rx_data <= rx_data;
    req.tx_data <= tx_data;
    req.tx_last <= tx_last;
    do @(posedge clk); while (req.ready !== 1'b1);
    sent++;
  endtask

  task automatic issue_op(cmd_t cmd, logic tx_last);
    issue(cmd, 8'($urandom), 8'($urandom), tx_last);
  endtask

  // stop requesting and let every outstanding result come back
  task automatic settle();
    @(negedge clk);
    req.valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
  endtask

  task automatic flush_transmit();
    do begin
      issue_op(CMD_TX_READY, 1'b0);
      settle();
    end while (seen_ready_pin !== 1'b1);
  endtask

  task automatic empty_receive();
    settle();
    while (seen_bytes_ready !== 1'b0) begin
      issue_op(CMD_POP, 1'b0);
      settle();
    end
  endtask

  // write exactly one store depth so the write position lands on the read position
  task automatic wrap_receive_store();
    flush_transmit();
    empty_receive();
    repeat (RX_DEPTH) issue_op(CMD_RX, 1'b0);
    issue_op(CMD_POP, 1'b0);
    repeat ($urandom_range(1, 4)) issue_op(CMD_RX, 1'b0);
    repeat (6) issue_op(CMD_POP, 1'b0);
  endtask

  task automatic longest_message_and_overflow();
    flush_transmit();
    issue_op(CMD_LOAD, 1'b1);
    flush_transmit();
    repeat (TX_DEPTH - 1) issue_op(CMD_LOAD, 1'b0);
    issue_op(CMD_LOAD, 1'b1);
    repeat (TX_DEPTH) issue_op(CMD_TX_READY, 1'b0);
    flush_transmit();
    repeat (TX_DEPTH) issue_op(CMD_LOAD, 1'b0);
    issue_op(CMD_LOAD, 1'($urandom));
    issue_op(CMD_LOAD, 1'b1);
    flush_transmit();
  endtask

  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    req_max_gap = pick_limit();
    res_max_stall = pick_limit();
    case (kind)
      0, 1, 2: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) issue_op(CMD_LOAD, i == n - 1);
        for (int i = 0; i <= n; i++) begin
          if ($urandom_range(0, 4) == 0) issue_op(cmd_t'($urandom_range(0, 3)), 1'($urandom));
          issue_op(CMD_TX_READY, 1'b0);
        end
      end
      3, 4: repeat ($urandom_range(1, 12)) issue_op(CMD_RX, 1'b0);
      5, 6: repeat ($urandom_range(1, 12)) issue_op(CMD_POP, 1'b0);
      7: begin
        repeat ($urandom_range(1, 5)) issue_op(CMD_LOAD, 1'b0);
        repeat ($urandom_range(1, 4)) issue_op(cmd_t'($urandom_range(0, 2)), 1'($urandom));
      end
      default: repeat ($urandom_range(1, 8)) issue_op(cmd_t'($urandom_range(0, 3)), 1'($urandom));
    endcase
  endtask

  initial begin
    req.valid = 1'b0;
    req.cmd = CMD_RX;
    req.rx_data = 8'h00;
    req.tx_data = 8'h00;
    req.tx_last = 1'b0;
    res.ready = 1'b0;
    sent = 0;
    req_max_gap = 2;
    res_max_stall = 2;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty pop and idle ready event, then three received bytes popped back
    issue(CMD_POP, 8'h00, 8'h00, 1'b0);
    issue(CMD_TX_READY, 8'h00, 8'h00, 1'b0);
    issue(CMD_RX, 8'h00, 8'hff, 1'b1);
    issue(CMD_RX, 8'hff, 8'h00, 1'b0);
    issue(CMD_RX, 8'h5a, 8'ha5, 1'b1);
    repeat (4) issue(CMD_POP, 8'hff, 8'hff, 1'b1);
    // two byte message, drop while sending, load while busy, then a one byte message
    issue(CMD_LOAD, 8'h00, 8'hff, 1'b0);
    issue(CMD_LOAD, 8'hff, 8'h00, 1'b1);
    issue(CMD_RX, 8'ha5, 8'h00, 1'b0);
    issue(CMD_LOAD, 8'h00, 8'h33, 1'b1);
    repeat (3) issue(CMD_TX_READY, 8'hff, 8'hff, 1'b1);
    issue(CMD_LOAD, 8'h00, 8'h7e, 1'b1);
    issue(CMD_TX_READY, 8'h00, 8'h00, 1'b0);
    issue(CMD_POP, 8'h00, 8'h00, 1'b0);

    while (sent < 100) random_burst();
    wrap_receive_store();
    while (sent < 450) random_burst();
    longest_message_and_overflow();
    while (sent < 1250) random_burst();

    settle();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_spi_slave_byte_buffer: clean");
    end else begin
      $display("tb_spi_slave_byte_buffer: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
